// File: hdl/tasp_pkg.sv
// Package for the two-axis Smith predictor: widths, register indexes, states.
// No dependencies.
`default_nettype none
package tasp_pkg;
   localparam int HistDepth = 1024;
   localparam int HistAw    = $clog2(HistDepth);
   localparam int FillW     = $clog2(HistDepth + 1);
   localparam int CsrIdxW   = 2;
   localparam int CsrDataW  = 22;
   localparam logic [9:0] MinT    = 10'd1000;
   localparam logic [9:0] MinStep = 10'd1000;

   typedef enum logic [CsrIdxW-1:0] {
      REG_ENABLE = 2'd0, REG_GAIN = 2'd1, REG_TCONST = 2'd2, REG_DELAY = 2'd3
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DSETUP, ST_DDIV, ST_HREAD, ST_HWAIT, ST_MSETUP, ST_MMUL,
      ST_MLOAD, ST_MDIV, ST_MNEXT, ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic busy;
   } div_ctl_type;
endpackage
`default_nettype wire

// File: hdl/tasp_if.sv
// Valid/ready channel interface, generic payload.
// Depends on nothing.
`default_nettype none
interface tasp_if #(parameter type payload_type = logic) (input wire logic clock);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/two_axis_smith_predictor.sv
// Two-axis Smith predictor with a first-order plant model per axis.
// Depends on tasp_pkg, tasp_ram, tasp_div.
//
// Use: an item on the req channel carries X/Y drive, X/Y measurement and the
// step time in us. One result transfer on rsp carries the corrected X/Y
// feedback: measurement + (undelayed model - delayed model), saturated.
// With enable low or step zero the measurement passes through: the block
// goes straight to ST_OUT, which registers rsp_valid.
// Otherwise one shared 64-bit restoring divider (one bit a cycle) does all
// the work: the delay count ceil(tau/max(dt,1ms)), then four model updates.
// The steps are the delay division, the history read, four model updates
// (setup, multiply, load, divide, write back each) and the output state,
// which registers rsp_valid.
// req_ready is low from acceptance until the result has been transferred and
// returns the cycle after, so a new item is taken only once the last result
// has gone out. A stalled receiver simply holds the block with the result
// registered.
// The multiplies (16x32 gain by drive, 47x16 magnitude by dt) sit in their
// own register stage before the divider.
// Reset (synchronous, active high) gives enable 0, gain 1.0, T 100 ms, tau 0
// and clears the models, write pointer and fill count. The history RAMs are
// not cleared: only entries younger than the fill count are ever read.
// Any csr write clears models, pointer and fill count as well.
`default_nettype none
module two_axis_smith_predictor import tasp_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic signed [31:0]   req_drive_x,
   input  wire logic signed [31:0]   req_drive_y,
   input  wire logic signed [31:0]   req_measured_x,
   input  wire logic signed [31:0]   req_measured_y,
   input  wire logic [15:0]          req_step_us,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic signed [31:0]        rsp_corrected_x,
   output logic signed [31:0]        rsp_corrected_y,
   input  wire logic                 csr_write_enable,
   input  wire logic [CsrIdxW-1:0]   csr_index,
   input  wire logic [CsrDataW-1:0]  csr_write_data
);
   // config
   logic               enable_ff;
   logic signed [15:0] gain_ff;
   logic [21:0]        tconst_ff;
   logic [19:0]        delay_ff;
   // model state: 0 mx, 1 my, 2 dmx, 3 dmy
   logic signed [31:0] model_ff [4];
   logic signed [31:0] model_in;
   logic [HistAw-1:0]  wptr_ff;
   logic [FillW-1:0]   fill_ff;
   // item registers
   logic signed [31:0] ux_ff, uy_ff, mx_ff, my_ff, dx_ff, dy_ff;
   logic [15:0]        dt_ff;
   logic               dvalid_ff;
   logic [1:0]         sel_ff;
   logic               neg_ff;
   logic [46:0]        mag_ff;
   logic [63:0]        num_ff;
   logic signed [31:0] cx_ff, cy_ff;
   logic               rsp_valid_ff;
   state_type          state_ff, state_in;

   logic [21:0]        t_eff;
   logic [15:0]        div_eff;
   logic [39:0]        den;
   logic               div_start;
   logic [63:0]        div_num;
   logic [39:0]        div_den;
   logic [63:0]        div_q;
   div_ctl_type        div_ctl;
   logic               hist_we;
   logic [HistAw-1:0]  rd_addr;
   logic [31:0]        hx_rd, hy_rd;

   // next-state and control
   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      hist_we   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready)
               state_in = (enable_ff && req_step_us != '0) ? ST_DSETUP : ST_OUT;
         end
         ST_DSETUP: begin div_start = 1'b1; hist_we = 1'b1; state_in = ST_DDIV; end
         ST_DDIV:   if (!div_ctl.busy) state_in = ST_HREAD;
         ST_HREAD:  state_in = ST_HWAIT;
         ST_HWAIT:  state_in = ST_MSETUP;
         ST_MSETUP: state_in = ST_MMUL;
         ST_MMUL:   state_in = ST_MLOAD;
         ST_MLOAD:  begin div_start = 1'b1; state_in = ST_MDIV; end
         ST_MDIV:   if (!div_ctl.busy) state_in = ST_MNEXT;
         ST_MNEXT:  state_in = (sel_ff == 2'd3) ? ST_OUT : ST_MSETUP;
         ST_OUT:    if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign t_eff   = (tconst_ff < {12'd0, MinT}) ? {12'd0, MinT} : tconst_ff;
   assign div_eff = (dt_ff < {6'd0, MinStep}) ? {6'd0, MinStep} : dt_ff;
   assign den     = {10'd0, t_eff, 8'd0};
   // delay division: (tau + div - 1) / div, else model numerator + den/2
   assign div_num = (state_ff == ST_DSETUP) ?
                    {43'd0, ({1'b0, delay_ff} + {5'd0, div_eff} - 21'd1)} :
                    num_ff + {25'd0, den[39:1]};
   assign div_den = (state_ff == ST_DSETUP) ? {24'd0, div_eff} : den;

   tasp_div u_div (.clock, .reset, .start(div_start), .dividend(div_num),
                   .divisor(div_den), .quotient(div_q), .ctl(div_ctl));

   // read index = wptr_new - d - 1 = old wptr - d (wptr_ff already advanced);
   // the delay quotient holds in the divider through HREAD and HWAIT
   assign rd_addr = wptr_ff - div_q[HistAw-1:0] - HistAw'(1);

   tasp_ram #(.Width(32), .Depth(HistDepth)) u_hist_x (.clock, .we(hist_we),
      .waddr(wptr_ff), .wdata(ux_ff), .raddr(rd_addr), .rdata(hx_rd));
   tasp_ram #(.Width(32), .Depth(HistDepth)) u_hist_y (.clock, .we(hist_we),
      .waddr(wptr_ff), .wdata(uy_ff), .raddr(rd_addr), .rdata(hy_rd));

   // state update with rounding result, saturated
   logic signed [33:0] upd;
   logic signed [33:0] qs;
   logic signed [63:0] prod;
   logic signed [31:0] drv;
   logic signed [47:0] diff;
   logic signed [33:0] sx, sy;
   always_comb begin
      // any quotient of 2^32 or more saturates the state either way
      qs  = (div_q[63:32] != '0) ? 34'sh1_0000_0000 : $signed({2'b0, div_q[31:0]});
      upd = neg_ff ? (34'(model_ff[sel_ff]) - qs) : (34'(model_ff[sel_ff]) + qs);
      if (upd > 34'sh0_7FFF_FFFF)       model_in = 32'sh7FFF_FFFF;
      else if (upd < -34'sh0_8000_0000) model_in = 32'sh8000_0000;
      else                              model_in = upd[31:0];
      case (sel_ff)
         2'd0:    drv = ux_ff;
         2'd1:    drv = uy_ff;
         2'd2:    drv = dvalid_ff ? dx_ff : 32'sd0;
         default: drv = dvalid_ff ? dy_ff : 32'sd0;
      endcase
      diff = 48'(gain_ff) * 48'(drv) - 48'(model_ff[sel_ff]) * 48'sd256;
      prod = 64'(mag_ff) * 64'(dt_ff);
      sx = 34'(mx_ff) + 34'(model_ff[0]) - 34'(model_ff[2]);
      // delayed Y model is written on the same edge: take it from the update
      sy = 34'(my_ff) + 34'(model_ff[1]) - 34'(model_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; rsp_valid_ff <= 1'b0;
         enable_ff <= 1'b0; gain_ff <= 16'sd256; tconst_ff <= 22'd100000;
         delay_ff <= '0; wptr_ff <= '0; fill_ff <= '0;
         for (int i = 0; i < 4; i++) model_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            case (csr_idx_type'(csr_index))
               REG_ENABLE: enable_ff <= csr_write_data[0];
               REG_GAIN:   gain_ff   <= csr_write_data[15:0];
               REG_TCONST: tconst_ff <= csr_write_data;
               REG_DELAY:  delay_ff  <= csr_write_data[19:0];
               default:    enable_ff <= enable_ff;
            endcase
            wptr_ff <= '0; fill_ff <= '0;
            for (int i = 0; i < 4; i++) model_ff[i] <= '0;
         end
         if (state_ff == ST_DSETUP) begin
            wptr_ff <= wptr_ff + HistAw'(1);
            if (fill_ff != FillW'(HistDepth)) fill_ff <= fill_ff + FillW'(1);
         end
         if (state_ff == ST_MNEXT) model_ff[sel_ff] <= model_in;
         if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_ready)) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // datapath registers, no reset
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid && req_ready) begin
         ux_ff <= req_drive_x; uy_ff <= req_drive_y;
         mx_ff <= req_measured_x; my_ff <= req_measured_y;
         dt_ff <= req_step_us; sel_ff <= 2'd0;
         cx_ff <= req_measured_x; cy_ff <= req_measured_y;
      end
      if (state_ff == ST_HREAD) begin
         dvalid_ff <= (div_q[63:FillW] == '0) && (div_q[FillW-1:0] < fill_ff);
      end
      if (state_ff == ST_HWAIT) begin dx_ff <= hx_rd; dy_ff <= hy_rd; end
      if (state_ff == ST_MSETUP) begin
         neg_ff <= diff[47];
         mag_ff <= diff[47] ? 47'(-diff) : 47'(diff);
      end
      if (state_ff == ST_MMUL) num_ff <= prod;
      if (state_ff == ST_MNEXT) begin
         sel_ff <= sel_ff + 2'd1;
         if (sel_ff == 2'd3) begin
            cx_ff <= (sx > 34'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                     (sx < -34'sh0_8000_0000) ? 32'sh8000_0000 : sx[31:0];
            cy_ff <= (sy > 34'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                     (sy < -34'sh0_8000_0000) ? 32'sh8000_0000 : sy[31:0];
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_corrected_x = cx_ff;
   assign rsp_corrected_y = cy_ff;

   a_no_ready_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready) else $error("ready while busy");
   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_ctl.busy) else $error("divider restarted while busy");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FillW'(HistDepth)) else $error("fill count overflow");
endmodule
`default_nettype wire

// File: hdl/tasp_ram.sv
// Generic single-port-write, registered-read RAM.
// No dependencies.
`default_nettype none
module tasp_ram #(parameter int Width = 32, parameter int Depth = 1024) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(Depth)-1:0] waddr,
   input  wire logic [Width-1:0]         wdata,
   input  wire logic [$clog2(Depth)-1:0] raddr,
   output logic      [Width-1:0]         rdata
);
   logic [Width-1:0] mem_ff [Depth];
   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      rdata <= mem_ff[raddr];
   end
endmodule
`default_nettype wire

// File: hdl/tasp_div.sv
// Restoring radix-2 unsigned divider, one quotient bit a cycle, 64/40 bits.
// Uses tasp_pkg.
`default_nettype none
module tasp_div import tasp_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] dividend,
   input  wire logic [39:0] divisor,
   output logic [63:0]      quotient,
   output div_ctl_type      ctl
);
   logic [63:0] quo_ff, quo_in;
   logic [40:0] rem_ff, rem_in;
   logic [39:0] dvs_ff, dvs_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [41:0] trial;

   always_comb begin
      quo_in = quo_ff; rem_in = rem_ff; dvs_in = dvs_ff; cnt_in = cnt_ff;
      trial  = {rem_ff, quo_ff[63]} - {2'b0, dvs_ff};
      if (start) begin
         quo_in = dividend; rem_in = '0; dvs_in = divisor; cnt_in = 7'd64;
      end else if (cnt_ff != 7'd0) begin
         cnt_in = cnt_ff - 7'd1;
         if (!trial[41]) begin
            rem_in = trial[40:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[39:0], quo_ff[63]};
            quo_in = {quo_ff[62:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
      quo_ff <= quo_in; rem_ff <= rem_in; dvs_ff <= dvs_in;
   end

   assign quotient  = quo_ff;
   assign ctl.start = start;
   assign ctl.busy  = (cnt_ff != 7'd0);
endmodule
`default_nettype wire

// File: bench/testbench.sv
// Self-checking bench for two_axis_smith_predictor: valid/ready driver and
// monitor, with an in-bench copy of the dual first-order model and history ring.
// Depends on hdl/tasp_pkg.sv, hdl/tasp_if.sv and the block's RTL.
`timescale 1ns / 100ps
module testbench import tasp_pkg::*; ();

   typedef struct packed {
      logic signed [31:0] drive_x;
      logic signed [31:0] drive_y;
      logic signed [31:0] measured_x;
      logic signed [31:0] measured_y;
      logic [15:0]        step_us;
   } sample_type;

   typedef struct packed {
      logic signed [31:0] corrected_x;
      logic signed [31:0] corrected_y;
   } feedback_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                csr_write_enable = 1'b0;
   logic [CsrIdxW-1:0]  csr_index = '0;
   logic [CsrDataW-1:0] csr_write_data = '0;

   always #2 clock = ~clock;

   tasp_if #(.payload_type(sample_type))   req_ch (clock);
   tasp_if #(.payload_type(feedback_type)) rsp_ch (clock);

   logic signed [31:0] rsp_cx, rsp_cy;
   logic               rsp_valid_w;
   assign rsp_ch.data  = '{rsp_cx, rsp_cy};
   assign rsp_ch.valid = rsp_valid_w;

   two_axis_smith_predictor uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_ch.valid),
      .req_ready        (req_ch.ready),
      .req_drive_x      (req_ch.data.drive_x),
      .req_drive_y      (req_ch.data.drive_y),
      .req_measured_x   (req_ch.data.measured_x),
      .req_measured_y   (req_ch.data.measured_y),
      .req_step_us      (req_ch.data.step_us),
      .rsp_valid        (rsp_valid_w),
      .rsp_ready        (rsp_ch.ready),
      .rsp_corrected_x  (rsp_cx),
      .rsp_corrected_y  (rsp_cy),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // ---------------------------------------------------------------------
   // Predictor copy of the block's configuration and state
   // ---------------------------------------------------------------------
   logic               cfg_enable = 1'b0;
   logic signed [15:0] cfg_gain   = 16'sd256;
   logic [21:0]        cfg_tconst = 22'd100000;
   logic [19:0]        cfg_delay  = 20'd0;

   logic signed [31:0] plant_x, plant_y, lagged_x, lagged_y;
   logic signed [31:0] drive_hist_x [HistDepth];
   logic signed [31:0] drive_hist_y [HistDepth];
   logic [HistAw-1:0]  hist_wptr;
   int unsigned        hist_fill;

   feedback_type feedback_due[$];  // corrections still owed by the block
   sample_type   pending[$];       // samples waiting for the driver
   int unsigned errors = 0;
   int unsigned n_issued = 0, n_accepted = 0, n_returned = 0;
   logic        gate = 1'b0;      // driver may present samples
   logic        idling_on = 1'b1;

   function automatic logic signed [31:0] clip32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // One Euler step: delta = dt*(K*u - 256*state)/(256*T), rounded half away.
   function automatic logic signed [31:0] euler_step(input logic signed [31:0] st,
         input logic signed [31:0] drv, input logic [15:0] dt, input logic [21:0] t_us);
      longint          diff;
      longint unsigned mag, den, q;
      logic            neg;
      diff = longint'(cfg_gain) * longint'(drv) - longint'(st) * 256;
      neg  = diff < 0;
      mag  = neg ? longint'(-diff) : diff;
      den  = longint'(t_us) * 256;
      q    = (mag * dt + den / 2) / den;
      return clip32(longint'(st) + (neg ? -longint'(q) : longint'(q)));
   endfunction

   task automatic clear_models();
      plant_x = 0; plant_y = 0; lagged_x = 0; lagged_y = 0;
      hist_wptr = '0; hist_fill = 0;
   endtask

   function automatic feedback_type predict_feedback(input sample_type s);
      feedback_type    f;
      logic [21:0]     t_us;
      int unsigned     divisor, lag;
      logic signed [31:0] old_x, old_y;
      logic [HistAw-1:0]  rd;
      f = '{s.measured_x, s.measured_y};
      if (!cfg_enable || s.step_us == 0) return f;
      t_us    = (cfg_tconst < 22'd1000) ? 22'd1000 : cfg_tconst;
      divisor = (s.step_us < 16'd1000) ? 1000 : s.step_us;
      lag     = (cfg_delay + divisor - 1) / divisor;
      plant_x = euler_step(plant_x, s.drive_x, s.step_us, t_us);
      plant_y = euler_step(plant_y, s.drive_y, s.step_us, t_us);
      drive_hist_x[hist_wptr] = s.drive_x;
      drive_hist_y[hist_wptr] = s.drive_y;
      hist_wptr = hist_wptr + 1'b1;
      if (hist_fill < HistDepth) hist_fill++;
      old_x = 0; old_y = 0;
      if (lag < hist_fill) begin
         rd    = hist_wptr - HistAw'(lag) - 1'b1;
         old_x = drive_hist_x[rd];
         old_y = drive_hist_y[rd];
      end
      lagged_x = euler_step(lagged_x, old_x, s.step_us, t_us);
      lagged_y = euler_step(lagged_y, old_y, s.step_us, t_us);
      f.corrected_x = clip32(longint'(s.measured_x) + longint'(plant_x) - longint'(lagged_x));
      f.corrected_y = clip32(longint'(s.measured_y) + longint'(plant_y) - longint'(lagged_y));
      return f;
   endfunction

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // ---------------------------------------------------------------------
   // Monitor: both transfers sampled at the rising edge
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      feedback_type want;
      feedback_type owed;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            owed         = predict_feedback(req_ch.data);
            feedback_due = {feedback_due, owed};
            n_accepted <= n_accepted + 1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            n_returned <= n_returned + 1;
            if (feedback_due.size() == 0) begin
               $display("unexpected transfer on rsp at %0t", $realtime);
               errors++;
            end else begin
               want = feedback_due.pop_front();
               if (rsp_ch.data.corrected_x !== want.corrected_x)
                  report("corrected_x", rsp_ch.data.corrected_x, want.corrected_x);
               if (rsp_ch.data.corrected_y !== want.corrected_y)
                  report("corrected_y", rsp_ch.data.corrected_y, want.corrected_y);
            end
         end
      end
   end

   function automatic int unsigned draw_gap();
      return idling_on ? $urandom_range(0, 18) : 0;
   endfunction

   // ---------------------------------------------------------------------
   // Driver: presents samples at the falling edge, random gap between them
   // ---------------------------------------------------------------------
   int unsigned req_gap = 0;
   initial begin
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
   end

   always @(negedge clock) begin
      logic done;
      if (!reset) begin
         done = req_ch.valid && (n_accepted == n_issued);
         if (req_ch.valid && !done) begin
            // still waiting for the transfer
         end else if (req_gap == 0 && gate && pending.size() != 0) begin
            req_ch.data  <= pending.pop_front();
            req_ch.valid <= 1'b1;
            n_issued     <= n_issued + 1;
            req_gap      <= draw_gap();
         end else begin
            req_ch.valid <= 1'b0;
            if (!done && req_gap != 0) req_gap <= req_gap - 1;
         end
      end
   end

   // Receiver: ready held low for a random stall after each transfer
   int unsigned rsp_stall = 0;
   int unsigned rsp_seen  = 0;
   initial rsp_ch.ready = 1'b0;

   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_seen != n_returned) begin
            rsp_seen <= n_returned;
            rsp_stall = draw_gap();
            rsp_ch.ready <= (rsp_stall == 0);
         end else if (rsp_stall != 0) begin
            rsp_stall--;
            rsp_ch.ready <= (rsp_stall == 0);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic csr_write(input csr_idx_type idx, input logic [CsrDataW-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         REG_ENABLE: cfg_enable = value[0];
         REG_GAIN:   cfg_gain   = value[15:0];
         REG_TCONST: cfg_tconst = value;
         REG_DELAY:  cfg_delay  = value[19:0];
         default:    ;
      endcase
      clear_models();
   endtask

   // Block is idle once every sample is through and every correction is back;
   // a pass-through sample has no trailing work, but allow for a full item.
   task automatic drain();
      while (pending.size() != 0 || req_ch.valid || feedback_due.size() != 0)
         @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   // Upper csr bits beyond a register's width are random: the block must drop them.
   task automatic configure(input logic en, input logic signed [15:0] gain,
                            input logic [21:0] tconst, input logic [19:0] dly);
      drain();
      gate = 1'b0;
      csr_write(REG_ENABLE, {21'($urandom_range(0, (1 << 21) - 1)), en});
      csr_write(REG_GAIN,   {6'($urandom_range(0, 63)), gain});
      csr_write(REG_TCONST, tconst);
      csr_write(REG_DELAY,  {2'($urandom_range(0, 3)), dly});
      idling_on = ($urandom_range(0, 3) != 0);
      gate = 1'b1;
   endtask

   function automatic logic signed [31:0] pick_q();
      case ($urandom_range(0, 5))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $signed($urandom_range(0, 'h3ffff)) - 32'sh20000;
         default: return $urandom;
      endcase
   endfunction

   // Step: mostly the base itself, with some zero, sub-millisecond and full range.
   function automatic logic [15:0] pick_step(input int unsigned base);
      case ($urandom_range(0, 9))
         0: return 16'd0;
         1: return 16'($urandom_range(1, 999));
         2: return 16'($urandom);
         default: return 16'(base);
      endcase
   endfunction

   task automatic queue_sample(input logic signed [31:0] ux, uy, mx, my,
                               input logic [15:0] dt);
      sample_type s;
      s       = '{ux, uy, mx, my, dt};
      pending = {pending, s};
   endtask

   task automatic queue_random(input int n, input int unsigned base);
      repeat (n) queue_sample(pick_q(), pick_q(), pick_q(), pick_q(), pick_step(base));
   endtask

   // ---------------------------------------------------------------------
   // Run
   // ---------------------------------------------------------------------
   initial begin
      clear_models();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Out of reset: enable low, every sample passes straight through.
      gate = 1'b1;
      queue_sample(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 16'd1000);
      queue_sample(32'sh12345678, -32'sh1, 32'sh0, 32'sh1, 16'd65535);

      // Directed: zero dead time, minimum T, maximum gain and extreme fields.
      configure(1'b1, 16'sh7fff, 22'd0, 20'd0);
      queue_sample(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 16'd1000);
      queue_sample(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 16'd65535);
      queue_sample(32'sh00010000, -32'sh00010000, 32'sh0, 32'sh0, 16'd0);
      queue_sample(32'sh00010000, -32'sh00010000, 32'sh0, 32'sh0, 16'd1);
      queue_sample(32'sh0, 32'sh0, 32'sh0, 32'sh0, 16'd999);

      // Directed: delay with short history, then history catching up.
      configure(1'b1, 16'sh8000, 22'd4000000, 20'd3000);
      queue_sample(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 16'd1000);
      queue_sample(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 16'd1000);
      queue_sample(32'sh7fffffff, 32'sh80000000, 32'sh0, 32'sh0, 16'd1000);
      queue_sample(32'sh40000000, 32'sh80000000, 32'sh0, 32'sh0, 16'd1000);
      queue_sample(-32'sh1, 32'sh1, 32'sh7fffffff, 32'sh80000000, 16'd500);
      queue_sample(32'sh0, 32'sh0, 32'sh1, 32'sh1, 16'd2999);

      // Directed: enable low again, then gain 1.0, minimum T.
      configure(1'b0, 16'sh0100, 22'd999, 20'd1000000);
      queue_sample(32'sh7fffffff, 32'sh7fffffff, 32'sh1234, -32'sh1234, 16'd1000);
      configure(1'b1, 16'sh0100, 22'd1000, 20'd1000000);
      queue_sample(32'sh7fffffff, 32'sh7fffffff, 32'sh1234, -32'sh1234, 16'd1000);
      queue_sample(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 16'd1000);

      // Random settings, short runs.
      configure(1'b1, 16'($urandom), 22'($urandom_range(0, 4000000)),
                20'($urandom_range(0, 20000)));
      queue_random(40, 1000);
      configure(1'b1, 16'sh7fff, 22'($urandom_range(1000, 20000)),
                20'($urandom_range(0, 8000)));
      queue_random(40, $urandom_range(500, 3000));
      configure(1'b1, 16'sh8000, 22'd4000000, 20'd0);
      queue_random(30, $urandom_range(1, 65535));
      configure(1'b0, 16'($urandom), 22'($urandom_range(0, 4000000)),
                20'($urandom_range(0, 1000000)));
      queue_random(20, 1000);

      // Sender holds off until every correction has come back.
      drain();
      configure(1'b1, 16'($urandom), 22'($urandom_range(1000, 200000)),
                20'($urandom_range(10000, 90000)));
      queue_random(50, $urandom_range(1000, 5000));

      // Long run: dead time of five hundred samples, history fills well past it.
      configure(1'b1, 16'($urandom_range(0, 'h1ff)), 22'($urandom_range(1000, 400000)),
                20'd500000);
      queue_random(700, 1000);

      configure(1'b1, 16'($urandom), 22'($urandom_range(0, 4000000)),
                20'($urandom_range(0, 1000000)));
      queue_random(40, $urandom_range(1, 2000));

      drain();
      if (errors == 0)
         $display("** two_axis_smith_predictor: PASSED **");
      else
         $display("** two_axis_smith_predictor: FAILED **");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #20000000;
      $display("** two_axis_smith_predictor: FAILED **");
      $finish;
   end
endmodule

// File: filelist.f
hdl/tasp_pkg.sv
hdl/tasp_if.sv
hdl/tasp_ram.sv
hdl/tasp_div.sv
hdl/two_axis_smith_predictor.sv
bench/testbench.sv
